/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked by clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define MKH_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent must hold at every edge where the antecedent holds.
`define MKH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the clock edge after one where the antecedent holds.
`define MKH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mkh_pkg.sv */
// ----------------------------------------------------------------------------
// Meiyan key hash package
// Constants and shared types of the Meiyan key hash block.
// ----------------------------------------------------------------------------
package mkh_pkg;

  localparam logic [31:0] Basis = 32'h811c9dc5;
  localparam logic [31:0] Mult  = 32'h000ad3e7;
  localparam int unsigned KeyW  = 64;
  localparam int unsigned CntW  = 4;
  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 32;
  localparam logic [CntW-1:0] FullCnt = 4'd8;

  // Control of the core's mix unit.
  typedef struct packed {
    logic        init;
    logic        step;
    logic [31:0] operand;
  } mkh_mix_ctl_t;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StMix  = 2'b10
  } mkh_state_e;

endpackage

/* rtl/mkh_mix_unit.sv */
// ----------------------------------------------------------------------------
// Meiyan mix unit
// Holds the hash; one step h = (h ^ v) * 0xad3e7 per cycle while step is set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mkh_mix_unit import mkh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mkh_mix_ctl_t ctl_i,
  output logic [31:0]  hash_o
);

  logic [31:0] hash_q, hash_d;
  logic [31:0] mixed;

  assign mixed = 32'((hash_q ^ ctl_i.operand) * Mult);

  always_comb begin
    hash_d = hash_q;
    if (ctl_i.init) begin
      hash_d = Basis;
    end else if (ctl_i.step) begin
      hash_d = mixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= Basis;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;

  `MKH_ASSERT(a_init_step_excl, !(ctl_i.init && ctl_i.step), "mix init and step together")
  `MKH_ASSERT_NXT(a_init_basis, ctl_i.init, hash_q == Basis, "hash not back at basis")

endmodule

/* rtl/meiyan_key_hash_core.sv */
// ----------------------------------------------------------------------------
// Meiyan key hash core
// Streams a key as 8-byte blocks and returns its 32-bit Meiyan hash.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (tdata from bit 0 up)                  Transfer
//  s_axis    in   key_bytes[63:0], byte_count[67:64]; tlast     per key block
//  m_axis    out  hash_value[31:0]                              per finished key
//
//  A non-last block is captured, then folded in one multiply step.
//  A last block is captured, folded in up to four multiply steps, then finished.
//  Each multiply step uses the single 32x20 multiplier in the mix unit.
//  Reset returns the running hash to the offset basis and empties the output.
//  A finished hash waits in the output register; a stalled output holds the
//  finish of the next key but not the capture of its blocks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module meiyan_key_hash_core import mkh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,   // key_bytes[63:0], byte_count[67:64]
  input  logic                 s_axis_tlast_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o    // hash_value[31:0]
);

  mkh_state_e state_q, state_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [2:0]      pos_q, pos_d;
  logic            full_q, full_d;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_data_q, out_data_d;

  mkh_mix_ctl_t mix_ctl;
  logic [31:0]  hash;
  logic         in_xfer;
  logic [CntW-1:0] in_cnt;
  logic [KeyW-1:0] key_shift;
  logic [31:0]  w0, w1, full_word, half_word, byte_word;
  logic         out_free;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cnt   = s_axis_tdata_i[KeyW+CntW-1:KeyW];
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign w0        = key_q[31:0];
  assign w1        = key_q[63:32];
  assign full_word = {w0[26:0], w0[31:27]} ^ w1;
  assign key_shift = key_q >> {pos_q, 3'b000};
  assign half_word = {16'h0000, key_shift[15:0]};
  assign byte_word = {{24{key_shift[7]}}, key_shift[7:0]};

  mkh_mix_unit u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mix_ctl),
    .hash_o (hash)
  );

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    full_d      = full_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mix_ctl     = '{init: 1'b0, step: 1'b0, operand: 32'h0};

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          key_d   = s_axis_tdata_i[KeyW-1:0];
          pos_d   = 3'd0;
          last_d  = s_axis_tlast_i;
          state_d = StMix;
          if (!s_axis_tlast_i || in_cnt >= FullCnt) begin
            full_d = 1'b1;
            rem_d  = '0;
          end else begin
            full_d = 1'b0;
            rem_d  = in_cnt;
          end
        end
      end
      StMix: begin
        if (full_q) begin
          mix_ctl.step    = 1'b1;
          mix_ctl.operand = full_word;
          full_d          = 1'b0;
          if (!last_q) begin
            state_d = StIdle;
          end
        end else if (rem_q >= 4'd2) begin
          mix_ctl.step    = 1'b1;
          mix_ctl.operand = half_word;
          rem_d           = rem_q - 4'd2;
          pos_d           = pos_q + 3'd2;
        end else if (rem_q == 4'd1) begin
          mix_ctl.step    = 1'b1;
          mix_ctl.operand = byte_word;
          rem_d           = '0;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = hash ^ {16'h0000, hash[31:16]};
          mix_ctl.init = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      pos_q       <= '0;
      full_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      pos_q       <= pos_d;
      full_q      <= full_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `MKH_ASSERT_IMP(a_idle_no_work, s_axis_tready_o, !full_q && rem_q == '0,
    "idle with mix work pending")
  `MKH_ASSERT(a_tail_in_range, ({1'b0, pos_q} + rem_q) <= FullCnt,
    "tail runs past the block")
  `MKH_ASSERT_IMP(a_full_no_tail, full_q, rem_q == '0, "full block with tail pending")
  `MKH_ASSERT_NXT(a_load_on_finish, mix_ctl.init, m_axis_tvalid_o,
    "hash finished without a result")

endmodule

/* bench/meiyan_key_hash_checker.sv */
// ----------------------------------------------------------------------------
// Meiyan key hash checker
// Watches both stream channels of the key hash core. It folds every accepted
// key block into its own running hash, queues the finished hash of each key,
// and compares every output transfer with the oldest queued hash.
// ----------------------------------------------------------------------------
module meiyan_key_hash_checker import mkh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [InTdataW-1:0]  s_tdata_i,
  input  logic                 s_tlast_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [OutTdataW-1:0] m_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] key_state;
  logic [31:0] finished_hashes[$];

  function automatic logic [31:0] mix_step(logic [31:0] h, logic [31:0] v);
    logic [31:0] prod;
    prod = (h ^ v) * Mult;
    return prod;
  endfunction

  function automatic logic [31:0] fold_full(logic [31:0] h, logic [KeyW-1:0] key);
    logic [31:0] w0;
    logic [31:0] w1;
    w0 = key[31:0];
    w1 = key[63:32];
    return mix_step(h, {w0[26:0], w0[31:27]} ^ w1);
  endfunction

  // From eight bytes up the full block is folded; a shorter tail folds as
  // two halfwords for the four-byte part, a halfword, then a signed char.
  function automatic logic [31:0] fold_tail(logic [31:0] h, logic [KeyW-1:0] key,
                                            logic [CntW-1:0] cnt);
    logic [KeyW-1:0] rest;
    logic [31:0]     acc;
    acc  = h;
    rest = key;
    if (cnt >= FullCnt) return fold_full(h, key);
    if (cnt[2]) begin
      acc  = mix_step(acc, {16'h0, rest[15:0]});
      acc  = mix_step(acc, {16'h0, rest[31:16]});
      rest = rest >> 32;
    end
    if (cnt[1]) begin
      acc  = mix_step(acc, {16'h0, rest[15:0]});
      rest = rest >> 16;
    end
    if (cnt[0]) acc = mix_step(acc, {{24{rest[7]}}, rest[7:0]});
    return acc;
  endfunction

  always @(posedge clk_i) begin : monitor
    logic [31:0] want;
    logic [31:0] fin;
    if (!rst_ni) begin
      key_state = Basis;
      finished_hashes.delete();
      fail_count_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (finished_hashes.size() == 0) begin
          $display("%0t: unexpected hash transfer, expected none, actual %08h",
                   $realtime, m_tdata_i);
          fail_count_o++;
        end else begin
          want = finished_hashes.pop_front();
          if (m_tdata_i !== want) begin
            $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                     $realtime, want, m_tdata_i);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (!s_tlast_i) begin
          key_state = fold_full(key_state, s_tdata_i[KeyW-1:0]);
        end else begin
          fin = fold_tail(key_state, s_tdata_i[KeyW-1:0], s_tdata_i[KeyW+CntW-1:KeyW]);
          finished_hashes.push_back(fin ^ (fin >> 16));
          key_state = Basis;
        end
      end
    end
    pending_o = finished_hashes.size();
  end

endmodule

/* bench/meiyan_key_hash_core_tb.sv */
// ----------------------------------------------------------------------------
// Meiyan key hash core testbench
// Streams directed and random keys into the core with bursty input traffic
// and a stalling output, including one long output stall and drain pauses.
// A checker beside the core predicts and compares every hash.
// ----------------------------------------------------------------------------
module meiyan_key_hash_core_tb import mkh_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 20;
  localparam int BlockTarget = 1550;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 3000;
  localparam int SettleCycles = 16;

  typedef enum int {
    SinkFree,
    SinkRandom,
    SinkSparse,
    SinkToggle
  } sink_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int blocks_sent = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  meiyan_key_hash_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  meiyan_key_hash_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IdleLimit);
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge where the next
  // transfer may be driven.
  task automatic send_block(input logic [KeyW-1:0] key, input logic [CntW-1:0] cnt,
                            input logic last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InTdataW - KeyW - CntW){1'b0}}, cnt, key};
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    blocks_sent++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_key(input int body_blocks, input logic [CntW-1:0] tail_cnt);
    for (int i = 0; i < body_blocks; i++) begin
      send_block({$urandom, $urandom}, CntW'($urandom_range(0, 15)), 1'b0);
    end
    send_block({$urandom, $urandom}, tail_cnt, 1'b1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : sink
    sink_mode_e mode;
    int left;
    int phase;
    mode  = SinkFree;
    left  = 0;
    phase = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        m_tready <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          left = $urandom_range(4, 60);
        end
        left--;
        phase++;
        case (mode)
          SinkFree:   m_tready <= 1'b1;
          SinkRandom: m_tready <= ($urandom_range(0, 1) == 1);
          SinkSparse: m_tready <= ($urandom_range(0, 3) == 0);
          default:    m_tready <= phase[1];
        endcase
      end
    end
  end

  initial begin : stimulus
    int key_count;
    int body_blocks;
    int pick;
    logic [CntW-1:0] tail_cnt;
    key_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every count on a one-block key, alternating negative bytes and all ones,
    // covering the empty key, the full final block and oversized counts.
    for (int c = 0; c < 16; c++) begin
      send_block(c[0] ? 64'h8080_8080_8080_8080 : 64'hffff_ffff_ffff_ffff,
                 CntW'(c), 1'b1);
    end
    send_block(64'h0000_0000_0000_0000, 4'd0, 1'b1);
    send_block(64'h0000_0000_0000_0000, 4'd8, 1'b1);
    send_block(64'hffff_ffff_ffff_ff7f, 4'd1, 1'b1);
    send_block(64'h7f7f_7f7f_7f7f_7f7f, 4'd7, 1'b1);
    // Body blocks ignore their count.
    send_block(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0);
    send_block(64'h0000_0000_0000_0000, 4'd15, 1'b0);
    send_block(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);
    send_block(64'hfedc_ba98_7654_3210, 4'd5, 1'b1);
    wait_drained();

    while (blocks_sent < BlockTarget) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) body_blocks = $urandom_range(0, 2);
      else if (pick < 9) body_blocks = $urandom_range(3, 6);
      else body_blocks = $urandom_range(7, 16);
      tail_cnt = ($urandom_range(0, 9) < 8) ? CntW'($urandom_range(0, 8))
                                            : CntW'($urandom_range(9, 15));
      send_key(body_blocks, tail_cnt);
      key_count++;
      if (key_count == 40) hold_off_req = 1'b1;
      if (key_count % 90 == 0) wait_drained();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mkh_pkg.sv
rtl/mkh_mix_unit.sv
rtl/meiyan_key_hash_core.sv
bench/meiyan_key_hash_checker.sv
bench/meiyan_key_hash_core_tb.sv
